@@ sv/tdg_pkg.sv @@
// Shared types and constants for the thermal derate guard.
// No dependencies; used by every other file of the block.
package tdg_pkg;

  localparam int unsigned CodeW  = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned LevelW = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_DERATE_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DERATE_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SHUTDOWN    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RESTORE     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STABLE_DLT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STABLE_NEED = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DWELL       = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_RECOVER     = 3'd7;

  // Protection levels
  localparam logic [LevelW-1:0] LVL_NORMAL   = 2'd0;
  localparam logic [LevelW-1:0] LVL_DERATE   = 2'd1;
  localparam logic [LevelW-1:0] LVL_SHUTDOWN = 2'd2;

  // Register reset values
  localparam logic [CodeW-1:0]  RST_DERATE_LOW  = 12'd1800;
  localparam logic [CodeW-1:0]  RST_DERATE_HIGH = 12'd2200;
  localparam logic [CodeW-1:0]  RST_SHUTDOWN    = 12'd2400;
  localparam logic [CodeW-1:0]  RST_RESTORE     = 12'd1299;
  localparam logic [CodeW-1:0]  RST_STABLE_DLT  = 12'd50;
  localparam logic [CountW-1:0] RST_STABLE_NEED = 4'd5;
  localparam logic [MsW-1:0]    RST_DWELL       = 16'd1000;
  localparam logic [MsW-1:0]    RST_RECOVER     = 16'd2000;

  typedef struct packed {
    logic [CodeW-1:0]  derate_low;
    logic [CodeW-1:0]  derate_high;
    logic [CodeW-1:0]  shutdown;
    logic [CodeW-1:0]  restore;
    logic [CodeW-1:0]  stable_delta;
    logic [CountW-1:0] stable_need;
    logic [MsW-1:0]    dwell_ms;
    logic [MsW-1:0]    recover_ms;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  mark_ms;
    logic [CountW-1:0] stable_cnt;
    logic [CodeW-1:0]  prev_code;
  } guard_state_t;

endpackage

@@ sv/tdg_if.sv @@
// Valid/ready channel interfaces for samples and results.
// Depends on tdg_pkg for field widths.
interface tdg_sample_if;
  logic                      valid;
  logic                      ready;
  logic [tdg_pkg::CodeW-1:0] sample_code;
  logic [tdg_pkg::TimeW-1:0] now_ms;

  modport source (output valid, output sample_code, output now_ms, input ready);
  modport sink   (input valid, input sample_code, input now_ms, output ready);
endinterface

interface tdg_result_if;
  logic                       valid;
  logic                       ready;
  logic [tdg_pkg::LevelW-1:0] protect_level;
  logic                       is_stable;

  modport source (output valid, output protect_level, output is_stable, input ready);
  modport sink   (input valid, input protect_level, input is_stable, output ready);
endinterface

@@ sv/tdg_cfg_regs.sv @@
// Configuration register file of the thermal derate guard.
// Depends on tdg_pkg.
module tdg_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [tdg_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [tdg_pkg::CfgDataW-1:0] wdata_i,
  output tdg_pkg::cfg_t                cfg_o
);

  tdg_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.derate_low   <= tdg_pkg::RST_DERATE_LOW;
      cfg_q.derate_high  <= tdg_pkg::RST_DERATE_HIGH;
      cfg_q.shutdown     <= tdg_pkg::RST_SHUTDOWN;
      cfg_q.restore      <= tdg_pkg::RST_RESTORE;
      cfg_q.stable_delta <= tdg_pkg::RST_STABLE_DLT;
      cfg_q.stable_need  <= tdg_pkg::RST_STABLE_NEED;
      cfg_q.dwell_ms     <= tdg_pkg::RST_DWELL;
      cfg_q.recover_ms   <= tdg_pkg::RST_RECOVER;
    end else if (we_i) begin
      unique case (idx_i)
        tdg_pkg::REG_DERATE_LOW:  cfg_q.derate_low   <= wdata_i[tdg_pkg::CodeW-1:0];
        tdg_pkg::REG_DERATE_HIGH: cfg_q.derate_high  <= wdata_i[tdg_pkg::CodeW-1:0];
        tdg_pkg::REG_SHUTDOWN:    cfg_q.shutdown     <= wdata_i[tdg_pkg::CodeW-1:0];
        tdg_pkg::REG_RESTORE:     cfg_q.restore      <= wdata_i[tdg_pkg::CodeW-1:0];
        tdg_pkg::REG_STABLE_DLT:  cfg_q.stable_delta <= wdata_i[tdg_pkg::CodeW-1:0];
        tdg_pkg::REG_STABLE_NEED: cfg_q.stable_need  <= wdata_i[tdg_pkg::CountW-1:0];
        tdg_pkg::REG_DWELL:       cfg_q.dwell_ms     <= wdata_i;
        tdg_pkg::REG_RECOVER:     cfg_q.recover_ms   <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/tdg_step.sv @@
// Per-sample evaluation: stability count, hysteresis and dwell timing.
// Pure combinational; depends on tdg_pkg.
module tdg_step (
  input  tdg_pkg::cfg_t              cfg_i,
  input  tdg_pkg::guard_state_t      state_i,
  input  logic [tdg_pkg::CodeW-1:0]  code_i,
  input  logic [tdg_pkg::TimeW-1:0]  now_i,
  output tdg_pkg::guard_state_t      state_o,
  output logic [tdg_pkg::LevelW-1:0] level_o,
  output logic                       stable_o
);

  logic [tdg_pkg::CodeW:0]   diff_raw;
  logic [tdg_pkg::CodeW-1:0] diff;
  logic [tdg_pkg::TimeW-1:0] elapsed;
  logic                      dwell_ok;
  logic                      recover_ok;
  logic                      in_band;
  logic                      hot;
  logic                      cool;
  logic [tdg_pkg::CountW-1:0] cnt_d;
  logic                      stable;

  assign diff_raw = {1'b0, code_i} - {1'b0, state_i.prev_code};
  // borrow set means code < prev: negate for magnitude
  assign diff     = diff_raw[tdg_pkg::CodeW] ? (state_i.prev_code - code_i)
                                             : diff_raw[tdg_pkg::CodeW-1:0];
  assign elapsed  = now_i - state_i.mark_ms;
  assign dwell_ok   = elapsed >= {{(tdg_pkg::TimeW-tdg_pkg::MsW){1'b0}}, cfg_i.dwell_ms};
  assign recover_ok = elapsed >= {{(tdg_pkg::TimeW-tdg_pkg::MsW){1'b0}}, cfg_i.recover_ms};
  assign in_band  = (code_i >= cfg_i.derate_low) && (code_i < cfg_i.derate_high);
  assign hot      = code_i >= cfg_i.shutdown;
  assign cool     = code_i <= cfg_i.restore;

  always_comb begin
    if (diff < cfg_i.stable_delta) begin
      cnt_d = (state_i.stable_cnt < cfg_i.stable_need) ? state_i.stable_cnt + 1'b1
                                                       : state_i.stable_cnt;
    end else begin
      cnt_d = '0;
    end
  end

  assign stable = cnt_d >= cfg_i.stable_need;

  always_comb begin
    state_o            = state_i;
    state_o.stable_cnt = cnt_d;
    state_o.prev_code  = code_i;
    if (stable) begin
      case (state_i.level)
        tdg_pkg::LVL_NORMAL: begin
          if (in_band) begin
            if (dwell_ok) begin
              state_o.level   = tdg_pkg::LVL_DERATE;
              state_o.mark_ms = now_i;
            end
          end else if (hot) begin
            if (dwell_ok) begin
              state_o.level   = tdg_pkg::LVL_SHUTDOWN;
              state_o.mark_ms = now_i;
            end
          end else begin
            state_o.mark_ms = now_i;
          end
        end
        tdg_pkg::LVL_DERATE: begin
          if (cool) begin
            if (dwell_ok) begin
              state_o.level   = tdg_pkg::LVL_NORMAL;
              state_o.mark_ms = now_i;
            end
          end else if (hot) begin
            if (dwell_ok) begin
              state_o.level   = tdg_pkg::LVL_SHUTDOWN;
              state_o.mark_ms = now_i;
            end
          end else begin
            state_o.mark_ms = now_i;
          end
        end
        default: begin
          // shutdown; mark is never re-armed while waiting here
          if (cool && recover_ok) begin
            state_o.level   = tdg_pkg::LVL_NORMAL;
            state_o.mark_ms = now_i;
          end
        end
      endcase
    end
  end

  assign level_o  = state_i.level;
  assign stable_o = stable;

endmodule

@@ sv/thermal_derate_guard.sv @@
// Thermal derate guard: over-temperature protection with hysteresis.
// An accepted request lands in the input register, then moves into the result
// register when that is free. Throughput: one request per cycle while the result
// side does not stall. A stalled result stalls the input register, which drops
// input ready in the same cycle. Reset (rst_ni low, async): level normal,
// mark/count/previous code zero, config at defaults, both stages empty.
module thermal_derate_guard (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tdg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tdg_pkg::CfgDataW-1:0] cfg_wdata_i,
  tdg_sample_if.sink                   sample_i,
  tdg_result_if.source                 result_o
);

  tdg_pkg::cfg_t         cfg;
  tdg_pkg::guard_state_t state_q;
  tdg_pkg::guard_state_t state_d;

  // Input register
  logic                      in_vld_q;
  logic [tdg_pkg::CodeW-1:0] in_code_q;
  logic [tdg_pkg::TimeW-1:0] in_now_q;

  // Result register
  logic                       out_vld_q;
  logic [tdg_pkg::LevelW-1:0] out_level_q;
  logic [tdg_pkg::LevelW-1:0] out_level_d;
  logic                       out_stable_q;
  logic                       out_stable_d;

  logic advance;   // input register may move into the result register
  logic take_in;   // request accepted this cycle

  tdg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Guard state advances exactly when a sample leaves the input register,
  // so the next sample in line always sees the updated state.
  tdg_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .code_i   (in_code_q),
    .now_i    (in_now_q),
    .state_o  (state_d),
    .level_o  (out_level_d),
    .stable_o (out_stable_d)
  );

  assign advance        = in_vld_q && (!out_vld_q || result_o.ready);
  assign sample_i.ready = !in_vld_q || advance;
  assign take_in        = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{level: tdg_pkg::LVL_NORMAL, mark_ms: '0, stable_cnt: '0,
                     prev_code: '0};
    end else begin
      if (sample_i.ready) begin
        in_vld_q <= sample_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_code_q <= sample_i.sample_code;
      in_now_q  <= sample_i.now_ms;
    end
    if (advance) begin
      out_level_q  <= out_level_d;
      out_stable_q <= out_stable_d;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.protect_level = out_level_q;
  assign result_o.is_stable     = out_stable_q;

endmodule

@@ sv/tdg_checker.sv @@
// Port-level checks for thermal_derate_guard, bound to the top level.
// Depends on tdg_pkg and thermal_derate_guard.
module tdg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [tdg_pkg::LevelW-1:0] out_level_i,
  input logic                       out_stable_i
);

  // Stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_level_i)
                                    && $stable(out_stable_i))
    else $error("result changed while stalled");

  // Level three is never reached
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_level_i != 2'd3))
    else $error("invalid protection level");

  // Input only back-pressures when a result is stuck downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // An accepted request moves from the input register into the result register
  // when the result side is ready while the request sits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after accepted request");

endmodule

bind thermal_derate_guard tdg_checker u_tdg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_level_i  (result_o.protect_level),
  .out_stable_i (result_o.is_stable)
);
